>>> hdl/lbf3_pkg.sv
// Shared types and constants for the 3x3 Laplacian / box filter.
// No dependencies; imported by laplacian_box_filter_3x3.
package lbf3_pkg;

  localparam int SAMPLE_W = 8;
  localparam int COORD_W  = 10;
  localparam int CHAN_W   = 2;
  localparam int DIM_W    = 11;
  localparam int CCNT_W   = 3;
  localparam int ACC_W    = 12;
  localparam int DIM_MAX  = 1024;

  localparam logic [ACC_W-1:0] LAP_OFFSET = 12'd128;
  localparam logic [ACC_W-1:0] PIX_MAX    = 12'd255;
  // floor(s/9) == (s*7282) >> 16 for every nine-sample sum (s <= 2295)
  localparam logic [12:0]      BOX_RECIP  = 13'd7282;
  localparam int               BOX_SHIFT  = 16;

  localparam logic [DIM_W-1:0]  RST_WIDTH    = 11'd640;
  localparam logic [DIM_W-1:0]  RST_HEIGHT   = 11'd480;
  localparam logic [CCNT_W-1:0] RST_CHANNELS = 3'd1;

  typedef enum logic [1:0] {
    CFG_FILTER_MODE   = 2'd0,
    CFG_IMAGE_WIDTH   = 2'd1,
    CFG_IMAGE_HEIGHT  = 2'd2,
    CFG_CHANNEL_COUNT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_LAPLACE = 1'b0,
    MODE_BOX     = 1'b1
  } filt_mode_e;

endpackage

>>> hdl/laplacian_box_filter_3x3.sv
// Streaming 3x3 Laplacian / box filter with two line stores in one RAM.
// Depends on lbf3_pkg.
//
//   channel  signals                                   direction  handshake
//   ------   ----------------------------------------  ---------  ---------------
//   input    in_sample_i                               in         in_valid_i/in_stall_o
//   output   out_filtered_o, out_column_o, out_row_o,  out        out_valid_o/out_stall_i
//            out_channel_o, out_frame_last_o
//   config   cfg_idx_i, cfg_wdata_i                    in         cfg_we_i
//
// One sample per clock while each sample yields at most one result and the output does
// not stall. A sample in the last column or last row yields up to four results, issued
// one per clock by the job sequencer while stage C is free; the input stalls for the
// extra cycles. A result passes from its sample's transfer through the job stage (with
// the RAM read), stage C and the output register.
// Reset clears counters, window history and control; the line RAM is not cleared.
// Output stall backs up through the job stage into the input stall.
module laplacian_box_filter_3x3
  import lbf3_pkg::*;
#(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [DIM_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] in_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] out_filtered_o,
  output logic [COORD_W-1:0]  out_column_o,
  output logic [COORD_W-1:0]  out_row_o,
  output logic [CHAN_W-1:0]   out_channel_o,
  output logic                out_frame_last_o
);

  localparam int WMAX  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int DEPTH = WMAX * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CH_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LW    = 2 * SAMPLE_W;

  // ---------------- configuration ----------------
  filt_mode_e         mode_q;
  logic [DIM_W-1:0]   width_q, height_q;
  logic [CCNT_W-1:0]  chans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LAPLACE;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      chans_q  <= RST_CHANNELS;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_FILTER_MODE:   mode_q   <= filt_mode_e'(cfg_wdata_i[0]);
        CFG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i;
        CFG_CHANNEL_COUNT: chans_q  <= cfg_wdata_i[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]   w_lim, h_lim;
  logic [CCNT_W-1:0]  nc_lim;
  logic [COORD_W-1:0] w_m1, h_m1;
  logic [CHAN_W-1:0]  nc_m1;

  always_comb begin
    if (width_q == '0)                   w_lim = DIM_W'(1);
    else if (width_q > DIM_W'(WMAX))     w_lim = DIM_W'(WMAX);
    else                                 w_lim = width_q;
    if (height_q == '0)                  h_lim = DIM_W'(1);
    else if (height_q > DIM_W'(DIM_MAX)) h_lim = DIM_W'(DIM_MAX);
    else                                 h_lim = height_q;
    if (chans_q == '0)                   nc_lim = CCNT_W'(1);
    else if (chans_q > CCNT_W'(MAX_CHANNELS)) nc_lim = CCNT_W'(MAX_CHANNELS);
    else                                 nc_lim = chans_q;
  end

  assign w_m1  = COORD_W'(w_lim - DIM_W'(1));
  assign h_m1  = COORD_W'(h_lim - DIM_W'(1));
  assign nc_m1 = CHAN_W'(nc_lim - CCNT_W'(1));

  // ---------------- position counters ----------------
  logic [COORD_W-1:0] col_q, row_q, col_e, row_e;
  logic [CHAN_W-1:0]  ch_q, ch_e;
  logic [CCNT_W-1:0]  ch_inc;
  logic               acc;
  logic [AW-1:0]      acc_addr;

  assign acc    = in_valid_i & ~in_stall_o;
  assign col_e  = ({1'b0, col_q} >= w_lim) ? w_m1 : col_q;
  assign row_e  = ({1'b0, row_q} >= h_lim) ? h_m1 : row_q;
  assign ch_e   = ({1'b0, ch_q} >= nc_lim) ? nc_m1 : ch_q;
  assign ch_inc = CCNT_W'(ch_e) + CCNT_W'(1);
  assign acc_addr = AW'(col_e) * AW'(MAX_CHANNELS) + AW'(ch_e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ch_q  <= '0;
    end else if (acc) begin
      if (ch_inc >= nc_lim) begin
        ch_q <= '0;
        if (col_e == w_m1) begin
          col_q <= '0;
          row_q <= (row_e == h_m1) ? '0 : row_e + COORD_W'(1);
        end else begin
          col_q <= col_e + COORD_W'(1);
          row_q <= row_e;
        end
      end else begin
        ch_q  <= CHAN_W'(ch_inc);
        col_q <= col_e;
        row_q <= row_e;
      end
    end
  end

  // ---------------- job stage (B) ----------------
  logic                b_valid_q;
  logic [SAMPLE_W-1:0] b_s_q;
  logic [COORD_W-1:0]  b_row_q, b_col_q;
  logic [CHAN_W-1:0]   b_ch_q;
  logic [AW-1:0]       b_addr_q;
  logic                b_up_q, b_lr_q, b_left_q, b_lc_q, b_lch_q;
  logic                b_yo_q, b_xo_q;
  logic                b_has_jobs, b_last_job, b_done, job_go, c_free, d_free;

  assign b_has_jobs = (b_up_q | b_lr_q) & (b_left_q | b_lc_q);
  assign b_last_job = (b_xo_q | ~b_lc_q) & (b_yo_q | ~b_lr_q);
  assign job_go     = b_valid_q & b_has_jobs & c_free;
  assign b_done     = b_valid_q & (~b_has_jobs | (b_last_job & c_free));
  assign in_stall_o = b_valid_q & ~b_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_yo_q    <= 1'b0;
      b_xo_q    <= 1'b0;
    end else if (acc) begin
      b_valid_q <= 1'b1;
      b_yo_q    <= (row_e == '0);
      b_xo_q    <= (col_e == '0);
    end else if (b_done) begin
      b_valid_q <= 1'b0;
    end else if (job_go) begin
      // walk columns within a row, then the next row
      if (!b_xo_q && b_lc_q) begin
        b_xo_q <= 1'b1;
      end else begin
        b_yo_q <= 1'b1;
        b_xo_q <= ~b_left_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_s_q    <= in_sample_i;
      b_row_q  <= row_e;
      b_col_q  <= col_e;
      b_ch_q   <= ch_e;
      b_addr_q <= acc_addr;
      b_up_q   <= (row_e != '0);
      b_lr_q   <= (row_e == h_m1);
      b_left_q <= (col_e != '0);
      b_lc_q   <= (col_e == w_m1);
      b_lch_q  <= (ch_e == nc_m1);
    end
  end

  // ---------------- line RAM {prev2, prev} ----------------
  logic [LW-1:0] line_mem [DEPTH];
  logic [LW-1:0] rd_q, fwd_word_q, line_word, wr_word;
  logic          fwd_q;

  assign line_word = fwd_q ? fwd_word_q : rd_q;
  assign wr_word   = {line_word[SAMPLE_W-1:0], b_s_q};

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q <= line_mem[acc_addr];
    end
    if (b_done) begin
      line_mem[b_addr_q] <= wr_word;
    end
  end

  // write-back lands in the same cycle as the next read of that entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (acc) begin
      fwd_q <= b_done && (b_addr_q == acc_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      fwd_word_q <= wr_word;
    end
  end

  // ---------------- window ----------------
  logic [2:0][SAMPLE_W-1:0] hist_q [MAX_CHANNELS][2];
  logic [CH_IW-1:0]         hk;
  logic [2:0][2:0][SAMPLE_W-1:0] win;   // [column][row]

  assign hk = b_ch_q[CH_IW-1:0];

  always_comb begin
    win[0] = hist_q[hk][1];
    win[1] = hist_q[hk][0];
    win[2] = {b_s_q, line_word[SAMPLE_W-1:0], line_word[LW-1:SAMPLE_W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist_q[i][0] <= '0;
        hist_q[i][1] <= '0;
      end
    end else if (b_done) begin
      hist_q[hk][1] <= hist_q[hk][0];
      hist_q[hk][0] <= win[2];
    end
  end

  // ---------------- per-job neighborhood ----------------
  logic [COORD_W-1:0]       job_row, job_col;
  logic [1:0]               cr, cc, ur, lc;
  logic [2:0][9:0]          rowsum;
  logic [ACC_W-1:0]         box_sum, lap_sum, job_raw;
  logic                     job_last;

  assign job_row = b_row_q - COORD_W'(1) + COORD_W'(b_yo_q);
  assign job_col = b_col_q - COORD_W'(1) + COORD_W'(b_xo_q);
  assign cr = 2'd1 + 2'(b_yo_q);
  assign cc = 2'd1 + 2'(b_xo_q);
  // replicate the edge: top/left neighbor falls back onto the center
  assign ur = (job_row != '0) ? cr - 2'd1 : cr;
  assign lc = (job_col != '0) ? cc - 2'd1 : cc;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rowsum[j] = 10'(win[lc][j]) + 10'(win[cc][j]) + 10'(win[2][j]);
    end
  end

  assign box_sum = ACC_W'(rowsum[ur]) + ACC_W'(rowsum[cr]) + ACC_W'(rowsum[2]);
  // modulo-4096 arithmetic; read back as signed in the output stage
  assign lap_sum = {2'b00, win[cc][cr], 2'b00} + LAP_OFFSET
                 - ACC_W'(win[cc][ur]) - ACC_W'(win[cc][2])
                 - ACC_W'(win[lc][cr]) - ACC_W'(win[2][cr]);
  assign job_raw  = (mode_q == MODE_BOX) ? box_sum : lap_sum;
  assign job_last = b_last_job & b_lr_q & b_lc_q & b_lch_q;

  // ---------------- stage C ----------------
  logic               c_valid_q, c_box_q, c_last_q;
  logic [ACC_W-1:0]   c_raw_q;
  logic [COORD_W-1:0] c_row_q, c_col_q;
  logic [CHAN_W-1:0]  c_ch_q;

  assign c_free = ~c_valid_q | d_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_free) begin
      c_valid_q <= job_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_go) begin
      c_raw_q  <= job_raw;
      c_box_q  <= (mode_q == MODE_BOX);
      c_row_q  <= job_row;
      c_col_q  <= job_col;
      c_ch_q   <= b_ch_q;
      c_last_q <= job_last;
    end
  end

  // ---------------- output register ----------------
  logic [24:0]         box_prod;
  logic [SAMPLE_W-1:0] filt_d;
  logic                out_valid_q, out_last_q;
  logic [SAMPLE_W-1:0] out_filt_q;
  logic [COORD_W-1:0]  out_row_q, out_col_q;
  logic [CHAN_W-1:0]   out_ch_q;

  assign d_free   = ~out_valid_q | ~out_stall_i;
  assign box_prod = 25'(c_raw_q) * 25'(BOX_RECIP);

  always_comb begin
    if (c_box_q)                filt_d = box_prod[BOX_SHIFT +: SAMPLE_W];
    else if (c_raw_q[ACC_W-1])  filt_d = '0;
    else if (c_raw_q > PIX_MAX) filt_d = PIX_MAX[SAMPLE_W-1:0];
    else                        filt_d = c_raw_q[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (d_free) begin
      out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_free && c_valid_q) begin
      out_filt_q <= filt_d;
      out_row_q  <= c_row_q;
      out_col_q  <= c_col_q;
      out_ch_q   <= c_ch_q;
      out_last_q <= c_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_filtered_o   = out_filt_q;
  assign out_column_o     = out_col_q;
  assign out_row_o        = out_row_q;
  assign out_channel_o    = out_ch_q;
  assign out_frame_last_o = out_last_q;

  // ---------------- assertions ----------------
  a_accept_loads_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> b_valid_q)
    else $error("accepted sample did not reach the job stage");

  a_forward_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && b_done && (b_addr_q == acc_addr)) |=> fwd_q)
    else $error("line RAM read-after-write hazard not forwarded");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_frame_last_o) |-> (out_row_o == h_m1) && (out_column_o == w_m1))
    else $error("frame_last flagged away from the final pixel");

  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_channel_o} < nc_lim))
    else $error("output channel beyond channel count");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for laplacian_box_filter_3x3: bursty sample stream,
// random output stall, scoreboard with its own line-buffer predictor.
// Depends on lbf3_pkg and laplacian_box_filter_3x3.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbf3_pkg::*;

  localparam int NCH          = 4;
  localparam int STORE_DEPTH  = DIM_MAX * NCH;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES  = 80;
  localparam int TARGET_ITEMS = 300;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [CHAN_W-1:0]   channel;
    logic                frame_end;
  } filt_result_t;

  class filter_scoreboard;
    filt_mode_e          mode;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [CCNT_W-1:0]   chan_reg;
    logic [SAMPLE_W-1:0] row_above  [STORE_DEPTH];
    logic [SAMPLE_W-1:0] row_above2 [STORE_DEPTH];
    logic [SAMPLE_W-1:0] hist [NCH][2][3];
    int                  col_pos, row_pos, chan_pos;
    // neighborhood of the current sample: [column c-2..c][row r-2..r]
    int                  win [3][3];
    int                  win_row, win_col, lim_w, lim_h;
    filt_result_t        expected_q[$];
    int                  errors, checked, samples, images;

    function new();
      mode       = MODE_LAPLACE;
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      chan_reg   = RST_CHANNELS;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
      for (int k = 0; k < NCH; k++)
        for (int a = 0; a < 2; a++)
          for (int j = 0; j < 3; j++) hist[k][a][j] = '0;
      col_pos  = 0;
      row_pos  = 0;
      chan_pos = 0;
      errors   = 0;
      checked  = 0;
      samples  = 0;
      images   = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [DIM_W-1:0] v);
      case (idx)
        CFG_FILTER_MODE:   mode = filt_mode_e'(v[0]);
        CFG_IMAGE_WIDTH:   width_reg = v;
        CFG_IMAGE_HEIGHT:  height_reg = v;
        CFG_CHANNEL_COUNT: chan_reg = v[CCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int fit(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int clip(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    // out-of-range geometry falls back to the nearest legal value
    function void align_counters(int w, int h, int nc);
      if (col_pos >= w) col_pos = w - 1;
      if (row_pos >= h) row_pos = h - 1;
      if (chan_pos >= nc) chan_pos = nc - 1;
    endfunction

    function int samples_left();
      int w, h, nc;
      w  = fit(width_reg, DIM_MAX);
      h  = fit(height_reg, DIM_MAX);
      nc = fit(chan_reg, NCH);
      align_counters(w, h, nc);
      return ((h - 1 - row_pos) * w + (w - 1 - col_pos)) * nc + (nc - 1 - chan_pos) + 1;
    endfunction

    // edge replication: clamp to the image, then to the three stored columns/rows
    function int tap(int y, int x);
      int ry, cx;
      ry = clip(clip(y, lim_h - 1) - win_row + 2, 2);
      cx = clip(clip(x, lim_w - 1) - win_col + 2, 2);
      return win[cx][ry];
    endfunction

    function logic [SAMPLE_W-1:0] filter_at(int y, int x);
      int acc;
      acc = 0;
      if (mode == MODE_BOX) begin
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++) acc += tap(y + dy, x + dx);
        return SAMPLE_W'(acc / 9);
      end
      acc = 4 * tap(y, x) - tap(y - 1, x) - tap(y + 1, x) - tap(y, x - 1)
            - tap(y, x + 1) + int'(LAP_OFFSET);
      return SAMPLE_W'(clip(acc, int'(PIX_MAX)));
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      int           w, h, nc, k, idx, nr, nx;
      int           rows [2];
      int           cols [2];
      bit           image_done;
      filt_result_t r;
      w  = fit(width_reg, DIM_MAX);
      h  = fit(height_reg, DIM_MAX);
      nc = fit(chan_reg, NCH);
      align_counters(w, h, nc);
      k       = chan_pos;
      idx     = col_pos * NCH + k;
      win_row = row_pos;
      win_col = col_pos;
      lim_w   = w;
      lim_h   = h;
      for (int j = 0; j < 3; j++) begin
        win[0][j] = hist[k][1][j];
        win[1][j] = hist[k][0][j];
      end
      win[2][0] = row_above2[idx];
      win[2][1] = row_above[idx];
      win[2][2] = s;

      nr = 0;
      nx = 0;
      if (row_pos >= 1) begin
        rows[nr] = row_pos - 1;
        nr++;
      end
      if (row_pos == h - 1) begin
        rows[nr] = row_pos;
        nr++;
      end
      if (col_pos >= 1) begin
        cols[nx] = col_pos - 1;
        nx++;
      end
      if (col_pos == w - 1) begin
        cols[nx] = col_pos;
        nx++;
      end
      image_done = (row_pos == h - 1) && (col_pos == w - 1) && (k == nc - 1);
      for (int i = 0; i < nr; i++)
        for (int j = 0; j < nx; j++) begin
          r.filtered  = filter_at(rows[i], cols[j]);
          r.column    = COORD_W'(cols[j]);
          r.row       = COORD_W'(rows[i]);
          r.channel   = CHAN_W'(k);
          r.frame_end = image_done && (i == nr - 1) && (j == nx - 1);
          expected_q.push_back(r);
        end
      if (image_done) images++;

      for (int j = 0; j < 3; j++) begin
        hist[k][1][j] = hist[k][0][j];
        hist[k][0][j] = SAMPLE_W'(win[2][j]);
      end
      row_above2[idx] = row_above[idx];
      row_above[idx]  = s;

      chan_pos++;
      if (chan_pos >= nc) begin
        chan_pos = 0;
        col_pos++;
        if (col_pos >= w) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= h) row_pos = 0;
        end
      end
      samples++;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] f, logic [COORD_W-1:0] col,
                               logic [COORD_W-1:0] row, logic [CHAN_W-1:0] ch,
                               logic fe);
      filt_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual value %0d row %0d col %0d ch %0d",
                 $time, f, row, col, ch);
        return;
      end
      want = expected_q.pop_front();
      compare_field("filtered", 16'(want.filtered), 16'(f));
      compare_field("out_column", 16'(want.column), 16'(col));
      compare_field("out_row", 16'(want.row), 16'(row));
      compare_field("out_channel", 16'(want.channel), 16'(ch));
      compare_field("frame_last", 16'(want.frame_end), 16'(fe));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flush_missing();
      errors += expected_q.size();
      $display("%0t: missing results: expected %0d more, actual 0", $time, expected_q.size());
      expected_q.delete();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_idx = '0;
  logic [DIM_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_filtered;
  logic [COORD_W-1:0]  out_column;
  logic [COORD_W-1:0]  out_row;
  logic [CHAN_W-1:0]   out_channel;
  logic                out_frame_last;

  filter_scoreboard sb;
  int               cycles = 0;
  bit               hold_req = 1'b0;
  int               hold_left = 0;
  int               phase_left = 0;
  int               stall_pct = 0;

  always #6 clk = ~clk;

  laplacian_box_filter_3x3 #(
    .MAX_WIDTH   (DIM_MAX),
    .MAX_CHANNELS(NCH)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_sample_i     (in_sample),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_filtered_o  (out_filtered),
    .out_column_o    (out_column),
    .out_row_o       (out_row),
    .out_channel_o   (out_channel),
    .out_frame_last_o(out_frame_last)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_filtered, out_column, out_row, out_channel, out_frame_last);
  end

  // receiver: phases of no, light and heavy stall, plus a long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 25;
          default: stall_pct = 70;
        endcase
      end
      phase_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [DIM_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(filt_mode_e m, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                           logic [CCNT_W-1:0] c);
    write_reg(CFG_FILTER_MODE, DIM_W'(m));
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_CHANNEL_COUNT, c);
  endtask

  task automatic push_sample(logic [SAMPLE_W-1:0] s);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // bursts of random length; gaps between bursts unless gapless
  task automatic stream(int n, bit gapless);
    int burst;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      push_sample(rand_sample());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (!gapless && $urandom_range(0, 2) != 0) idle_input($urandom_range(1, 10));
      end
    end
    idle_input(1);
  endtask

  // wait until every expected result is out, then let the pipeline empty
  task automatic settle();
    int n;
    n = 0;
    while (sb.pending() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (sb.pending() > 0) sb.flush_missing();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    filt_mode_e       m;
    logic [DIM_W-1:0] w, h;
    logic [CCNT_W-1:0] c;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // checkerboard drives the Laplacian into both clamps
    configure(MODE_LAPLACE, 3, 3, 1);
    for (int i = 0; i < 9; i++) push_sample((i % 2 == 0) ? 8'hFF : 8'h00);
    idle_input(1);
    settle();

    // zero width/height and oversized channel count fall back to 1x1, 4 channels
    configure(MODE_BOX, 0, 0, 7);
    push_sample(8'h00);
    push_sample(8'hFF);
    push_sample(8'h01);
    push_sample(8'h80);
    idle_input(1);
    settle();

    configure(MODE_BOX, 2, 2, 2);
    for (int i = 0; i < 8; i++) push_sample(8'hFF);
    idle_input(1);
    settle();

    // long output hold with a gapless sender: input must back up
    configure(filt_mode_e'($urandom_range(0, 1)), 8, 4, 2);
    hold_req = 1'b1;
    stream(sb.samples_left(), 1'b1);
    settle();

    // width shrinks within row 0 of an oversized image
    configure(filt_mode_e'($urandom_range(0, 1)), 11'h7FF, 2, 1);
    stream(12, 1'b0);
    settle();
    write_reg(CFG_IMAGE_WIDTH, DIM_W'($urandom_range(1, 6)));
    stream(sb.samples_left(), 1'b0);
    settle();

    // height shrinks below the current row
    configure(filt_mode_e'($urandom_range(0, 1)), 2, 11'h7FF, 1);
    stream(6, 1'b0);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, DIM_W'($urandom_range(1, 3)));
    stream(sb.samples_left(), 1'b0);
    settle();

    // channel count and mode change within a pixel
    m = filt_mode_e'($urandom_range(0, 1));
    configure(m, 3, 3, 4);
    stream(7, 1'b0);
    settle();
    write_reg(CFG_CHANNEL_COUNT, 2);
    write_reg(CFG_FILTER_MODE, DIM_W'(~m));
    stream(sb.samples_left(), 1'b0);
    settle();

    while (sb.samples < TARGET_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        m = filt_mode_e'($urandom_range(0, 1));
        w = ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 10));
        h = DIM_W'($urandom_range(1, 5));
        case ($urandom_range(0, 9))
          0: c = '0;
          1: c = CCNT_W'($urandom_range(5, 7));
          default: c = CCNT_W'($urandom_range(1, 4));
        endcase
        configure(m, w, h, c);
      end
      stream(sb.samples_left(), $urandom_range(0, 3) == 0);
      settle();
    end

    $display("Streamed %0d samples through %0d images in both filter modes; %0d results compared.",
             sb.samples, sb.images, sb.checked);
    $display("Covered clamped register values, geometry changes within an image and output backpressure.");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
